/* rtl/fgta_pkg.sv */
// ----------------------------------------------------------------------------
// fgta_pkg
// shared constants, register indexes and types of the final glide
// transition alert unit
// ----------------------------------------------------------------------------
package fgta_pkg;

    localparam int MARGIN_WIDTH_DEF = 24;
    localparam int TIME_WIDTH       = 32;
    localparam int CFG_DATA_WIDTH   = 32;
    localparam int CFG_INDEX_WIDTH  = 3;
    localparam int ALERT_WIDTH      = 2;
    localparam int COEF_WIDTH       = 16;
    localparam int FILT_SHIFT       = 16;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CHECK_INTERVAL = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAP_BEFORE     = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAP_FINAL      = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UPPER_MARGIN   = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOWER_MARGIN   = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_REACH_MARGIN   = 3'd5;

    // register reset values
    localparam logic [TIME_WIDTH-1:0] RST_CHECK_INTERVAL = 32'd1000;
    localparam logic [TIME_WIDTH-1:0] RST_GAP_BEFORE     = 32'd300000;
    localparam logic [TIME_WIDTH-1:0] RST_GAP_FINAL      = 32'd60000;
    localparam int RST_UPPER_MARGIN = 12800;
    localparam int RST_LOWER_MARGIN = -12800;
    localparam int RST_REACH_MARGIN = 256;

    // filter coefficients, q0.16
    localparam logic [COEF_WIDTH-1:0] COEF_NEW = 16'd13107;
    localparam logic [COEF_WIDTH-1:0] COEF_OLD = 16'd52429;
    localparam logic [COEF_WIDTH-1:0] COEF_RND = 16'd32768;

    // alert codes
    localparam logic [ALERT_WIDTH-1:0] ALERT_NONE  = 2'd0;
    localparam logic [ALERT_WIDTH-1:0] ALERT_ABOVE = 2'd1;
    localparam logic [ALERT_WIDTH-1:0] ALERT_BELOW = 2'd2;

    // configuration set, upper and lower margins at full data width, reach one bit less
    typedef struct packed {
        logic [TIME_WIDTH-1:0]            check_interval;
        logic [TIME_WIDTH-1:0]            gap_before;
        logic [TIME_WIDTH-1:0]            gap_final;
        logic signed [CFG_DATA_WIDTH-1:0] upper_margin;
        logic signed [CFG_DATA_WIDTH-1:0] lower_margin;
        logic [CFG_DATA_WIDTH-2:0]        reach_margin;
    } fgta_cfg_t;

endpackage

/* rtl/fgta_in_if.sv */
// ----------------------------------------------------------------------------
// fgta_in_if
// update channel: one navigation update per transaction
// ----------------------------------------------------------------------------
interface fgta_in_if #(
    parameter int MARGIN_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic [31:0]                    time_ms;
    logic                           flying;
    logic                           has_task;
    logic                           on_final_glide;
    logic signed [MARGIN_WIDTH-1:0] altitude_margin;

    modport source (
        output valid, time_ms, flying, has_task, on_final_glide, altitude_margin,
        input  ready
    );

    modport sink (
        input  valid, time_ms, flying, has_task, on_final_glide, altitude_margin,
        output ready
    );
endinterface

/* rtl/fgta_out_if.sv */
// ----------------------------------------------------------------------------
// fgta_out_if
// result channel: alert code and filtered margin per transaction
// ----------------------------------------------------------------------------
interface fgta_out_if #(
    parameter int MARGIN_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic [1:0]                     alert;
    logic signed [MARGIN_WIDTH-1:0] filtered_margin;

    modport source (
        output valid, alert, filtered_margin,
        input  ready
    );

    modport sink (
        input  valid, alert, filtered_margin,
        output ready
    );
endinterface

/* rtl/fgta_cfg.sv */
// ----------------------------------------------------------------------------
// fgta_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module fgta_cfg #(
    parameter int MARGIN_WIDTH = fgta_pkg::MARGIN_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [fgta_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [fgta_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output fgta_pkg::fgta_cfg_t                   cfg
);
    import fgta_pkg::*;

    logic [TIME_WIDTH-1:0]          check_interval_reg;
    logic [TIME_WIDTH-1:0]          gap_before_reg;
    logic [TIME_WIDTH-1:0]          gap_final_reg;
    logic signed [MARGIN_WIDTH-1:0] upper_margin_reg;
    logic signed [MARGIN_WIDTH-1:0] lower_margin_reg;
    logic [MARGIN_WIDTH-2:0]        reach_margin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_interval_reg <= RST_CHECK_INTERVAL;
            gap_before_reg     <= RST_GAP_BEFORE;
            gap_final_reg      <= RST_GAP_FINAL;
            upper_margin_reg   <= MARGIN_WIDTH'(RST_UPPER_MARGIN);
            lower_margin_reg   <= MARGIN_WIDTH'(RST_LOWER_MARGIN);
            reach_margin_reg   <= (MARGIN_WIDTH-1)'(RST_REACH_MARGIN);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CHECK_INTERVAL: check_interval_reg <= cfg_data[TIME_WIDTH-1:0];
                REG_GAP_BEFORE:     gap_before_reg     <= cfg_data[TIME_WIDTH-1:0];
                REG_GAP_FINAL:      gap_final_reg      <= cfg_data[TIME_WIDTH-1:0];
                REG_UPPER_MARGIN:   upper_margin_reg   <= cfg_data[MARGIN_WIDTH-1:0];
                REG_LOWER_MARGIN:   lower_margin_reg   <= cfg_data[MARGIN_WIDTH-1:0];
                REG_REACH_MARGIN:   reach_margin_reg   <= cfg_data[MARGIN_WIDTH-2:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        cfg.check_interval = check_interval_reg;
        cfg.gap_before     = gap_before_reg;
        cfg.gap_final      = gap_final_reg;
        cfg.upper_margin   = CFG_DATA_WIDTH'(upper_margin_reg);
        cfg.lower_margin   = CFG_DATA_WIDTH'(lower_margin_reg);
        cfg.reach_margin   = (CFG_DATA_WIDTH-1)'(reach_margin_reg);
    end

endmodule

/* rtl/fgta_filter.sv */
// ----------------------------------------------------------------------------
// fgta_filter
// first order low-pass step, 0.2 new / 0.8 old, rounded and saturated
// ----------------------------------------------------------------------------
module fgta_filter #(
    parameter int MARGIN_WIDTH = fgta_pkg::MARGIN_WIDTH_DEF
) (
    input  logic signed [MARGIN_WIDTH-1:0] margin,
    input  logic signed [MARGIN_WIDTH-1:0] prev,
    output logic signed [MARGIN_WIDTH-1:0] filtered
);
    import fgta_pkg::*;

    localparam int PW = MARGIN_WIDTH + COEF_WIDTH + 1;
    localparam int SW = MARGIN_WIDTH + COEF_WIDTH + 3;
    localparam logic signed [SW-1:0] SAT_HI =
        {{(SW-MARGIN_WIDTH+1){1'b0}}, {(MARGIN_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

    logic signed [PW-1:0] new_term;
    logic signed [PW-1:0] old_term;
    logic signed [SW-1:0] sum_w;
    logic signed [SW-1:0] shifted;

    always_comb
    begin
        new_term = margin * $signed({1'b0, COEF_NEW});
        old_term = prev * $signed({1'b0, COEF_OLD});
        sum_w    = SW'(new_term) + SW'(old_term) + $signed(SW'(COEF_RND));
        shifted  = sum_w >>> FILT_SHIFT;
        if (shifted > SAT_HI)
            filtered = SAT_HI[MARGIN_WIDTH-1:0];
        else if (shifted < SAT_LO)
            filtered = SAT_LO[MARGIN_WIDTH-1:0];
        else
            filtered = shifted[MARGIN_WIDTH-1:0];
    end

endmodule

/* rtl/fgta_core.sv */
// ----------------------------------------------------------------------------
// fgta_core
// check and notify timers, hysteresis state and event decision
// ----------------------------------------------------------------------------
module fgta_core #(
    parameter int MARGIN_WIDTH = fgta_pkg::MARGIN_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fgta_pkg::fgta_cfg_t                  cfg,
    input  logic                                 step,
    input  logic [fgta_pkg::TIME_WIDTH-1:0]      time_ms,
    input  logic                                 flying,
    input  logic                                 has_task,
    input  logic                                 on_final_glide,
    input  logic signed [MARGIN_WIDTH-1:0]       altitude_margin,
    output logic [fgta_pkg::ALERT_WIDTH-1:0]     alert,
    output logic signed [MARGIN_WIDTH-1:0]       filtered_margin
);
    import fgta_pkg::*;

    logic signed [MARGIN_WIDTH-1:0] filt_reg, filt_next;
    logic signed [MARGIN_WIDTH-1:0] rem_reg, rem_next;
    logic [TIME_WIDTH-1:0]          chk_time_reg, chk_time_next;
    logic                           chk_valid_reg, chk_valid_next;
    logic [TIME_WIDTH-1:0]          alr_time_reg, alr_time_next;
    logic                           alr_valid_reg, alr_valid_next;

    logic signed [MARGIN_WIDTH-1:0] filt_new;
    logic signed [MARGIN_WIDTH-1:0] upper;
    logic signed [MARGIN_WIDTH-1:0] lower;
    logic signed [MARGIN_WIDTH:0]   reach_pos;
    logic signed [MARGIN_WIDTH:0]   reach_neg;
    logic signed [MARGIN_WIDTH:0]   f_ext;
    logic signed [MARGIN_WIDTH:0]   rem_ext;
    logic [TIME_WIDTH:0]            chk_due;
    logic [TIME_WIDTH:0]            alr_due;
    logic [TIME_WIDTH-1:0]          gap;
    logic                           active;
    logic                           restart;
    logic                           check;
    logic                           cond;
    logic                           notify_ok;
    logic                           fire;

    fgta_filter #(
        .MARGIN_WIDTH (MARGIN_WIDTH)
    ) u_filter (
        .margin   (altitude_margin),
        .prev     (filt_reg),
        .filtered (filt_new)
    );

    always_comb
    begin
        upper     = cfg.upper_margin[MARGIN_WIDTH-1:0];
        lower     = cfg.lower_margin[MARGIN_WIDTH-1:0];
        reach_pos = $signed({2'b00, cfg.reach_margin[MARGIN_WIDTH-2:0]});
        reach_neg = -reach_pos;

        active  = flying && (time_ms != '0);
        restart = !chk_valid_reg || (time_ms < chk_time_reg);
        chk_due = {1'b0, chk_time_reg} + {1'b0, cfg.check_interval};
        check   = active && (restart || ({1'b0, time_ms} >= chk_due));

        filt_next      = filt_reg;
        rem_next       = rem_reg;
        chk_time_next  = chk_time_reg;
        chk_valid_next = chk_valid_reg;
        alr_time_next  = alr_time_reg;
        alr_valid_next = alr_valid_reg;
        cond           = 1'b0;
        gap            = cfg.gap_before;
        alert          = ALERT_NONE;

        if (has_task)
            filt_next = filt_new;
        f_ext   = (MARGIN_WIDTH+1)'(filt_new);
        rem_ext = (MARGIN_WIDTH+1)'(rem_reg);

        if (check)
        begin
            chk_time_next  = time_ms;
            chk_valid_next = 1'b1;
            if (has_task)
            begin
                if (!on_final_glide)
                begin
                    if (filt_new > upper && rem_reg < lower)
                        cond = 1'b1;
                    else if (filt_new < lower)
                        rem_next = filt_new;
                end
                else
                begin
                    gap = cfg.gap_final;
                    if (rem_reg < lower && f_ext > reach_pos)
                        cond = 1'b1;
                    else if (rem_ext > reach_pos && filt_new < lower)
                    begin
                        rem_next = filt_new;
                        cond     = 1'b1;
                    end
                end
            end
        end
        else
        begin
            filt_next = filt_reg;
        end

        alr_due   = {1'b0, alr_time_reg} + {1'b0, gap};
        notify_ok = !alr_valid_reg || (time_ms < alr_time_reg) ||
                    ({1'b0, time_ms} >= alr_due);
        fire      = check && cond && notify_ok && !restart;

        if (fire)
        begin
            alr_time_next  = time_ms;
            alr_valid_next = 1'b1;
            rem_next       = filt_new;
            if (f_ext > reach_pos)
                alert = ALERT_ABOVE;
            else if (f_ext < reach_neg)
                alert = ALERT_BELOW;
        end

        if (check && restart)
        begin
            alr_valid_next = 1'b0;
            rem_next       = filt_next;
        end

        filtered_margin = filt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg      <= '0;
            rem_reg       <= '0;
            chk_time_reg  <= '0;
            chk_valid_reg <= 1'b0;
            alr_time_reg  <= '0;
            alr_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            filt_reg      <= filt_next;
            rem_reg       <= rem_next;
            chk_time_reg  <= chk_time_next;
            chk_valid_reg <= chk_valid_next;
            alr_time_reg  <= alr_time_next;
            alr_valid_reg <= alr_valid_next;
        end
    end

endmodule

/* rtl/final_glide_transition_alert_unit.sv */
// ----------------------------------------------------------------------------
// final_glide_transition_alert_unit
// final glide transition alert: filters the altitude margin of each
// navigation update and raises above / below final glide events
//
// in_ch takes one update per transaction (valid/ready), out_ch returns one
// result per update, in order: alert code and filtered margin.
// an update sits in an input register; the filter and event logic run
// between that register and the result register, which drives out_ch.
// throughput is one update per cycle while out_ch does not stall; the
// filter/decision path against the state registers sets that figure.
// while out_ch stalls, the input register still takes one more update;
// in_ch.ready then drops until the result register is emptied.
// the user must write configuration through cfg_we / cfg_index / cfg_data
// only while no update is in flight (not enforced); unknown indexes are ignored.
// reset empties both registers, loads the register defaults and clears
// the filter, remembered margin and both timers.
// ----------------------------------------------------------------------------
module final_glide_transition_alert_unit #(
    parameter int MARGIN_WIDTH = fgta_pkg::MARGIN_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fgta_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [fgta_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    fgta_in_if.sink                              in_ch,
    fgta_out_if.source                           out_ch
);
    import fgta_pkg::*;

    fgta_cfg_t cfg;

    logic                           in_valid_reg, in_valid_next;
    logic [TIME_WIDTH-1:0]          in_time_reg;
    logic                           in_flying_reg;
    logic                           in_task_reg;
    logic                           in_final_reg;
    logic signed [MARGIN_WIDTH-1:0] in_margin_reg;

    logic                           out_valid_reg, out_valid_next;
    logic [ALERT_WIDTH-1:0]         out_alert_reg;
    logic signed [MARGIN_WIDTH-1:0] out_filt_reg;

    logic                           advance;
    logic                           step;
    logic                           in_take;
    logic [ALERT_WIDTH-1:0]         core_alert;
    logic signed [MARGIN_WIDTH-1:0] core_filt;

    fgta_cfg #(
        .MARGIN_WIDTH (MARGIN_WIDTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fgta_core #(
        .MARGIN_WIDTH (MARGIN_WIDTH)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .step            (step),
        .time_ms         (in_time_reg),
        .flying          (in_flying_reg),
        .has_task        (in_task_reg),
        .on_final_glide  (in_final_reg),
        .altitude_margin (in_margin_reg),
        .alert           (core_alert),
        .filtered_margin (core_filt)
    );

    always_comb
    begin
        advance  = !out_valid_reg || out_ch.ready;
        step     = in_valid_reg && advance;
        in_ch.ready = !in_valid_reg || advance;
        in_take  = in_ch.valid && in_ch.ready;

        if (in_ch.ready)
            in_valid_next = in_ch.valid;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = in_valid_reg;
        else
            out_valid_next = out_valid_reg;

        out_ch.valid           = out_valid_reg;
        out_ch.alert           = out_alert_reg;
        out_ch.filtered_margin = out_filt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_time_reg   <= in_ch.time_ms;
            in_flying_reg <= in_ch.flying;
            in_task_reg   <= in_ch.has_task;
            in_final_reg  <= in_ch.on_final_glide;
            in_margin_reg <= in_ch.altitude_margin;
        end
        if (step)
        begin
            out_alert_reg <= core_alert;
            out_filt_reg  <= core_filt;
        end
    end

endmodule

/* bench/final_glide_transition_alert_unit_tb.sv */
// ----------------------------------------------------------------------------
// final_glide_transition_alert_unit_tb
// self-checking bench for the final glide transition alert unit
//
// drives navigation updates in random bursts, stalls the result channel,
// and predicts alert code and filtered margin of every update in order:
// a directed opener at the register defaults, then random phases under
// several register settings, the extremes among them
// ----------------------------------------------------------------------------
module final_glide_transition_alert_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fgta_pkg::*;

    localparam int MW = MARGIN_WIDTH_DEF;
    localparam longint NEW_WEIGHT = 13107;
    localparam longint OLD_WEIGHT = 52429;
    localparam longint HALF_LSB   = 32768;
    localparam longint MARGIN_MAX = (longint'(1) <<< (MW - 1)) - 1;
    localparam longint MARGIN_MIN = -MARGIN_MAX - 1;
    localparam logic signed [MW-1:0] MARGIN_TOP    = {1'b0, {(MW-1){1'b1}}};
    localparam logic signed [MW-1:0] MARGIN_BOTTOM = {1'b1, {(MW-1){1'b0}}};
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_A = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_B = 3'd7;
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        logic [TIME_WIDTH-1:0]  time_ms;
        bit                     flying;
        bit                     has_task;
        bit                     on_final;
        logic signed [MW-1:0]   margin;
    } glide_update_t;

    typedef struct {
        logic [ALERT_WIDTH-1:0] alert;
        logic [MW-1:0]          margin;
    } glide_result_t;

    class alert_tracker;
        logic [TIME_WIDTH-1:0] check_interval;
        logic [TIME_WIDTH-1:0] gap_before;
        logic [TIME_WIDTH-1:0] gap_final;
        longint                upper;
        longint                lower;
        longint                reach;
        longint                filt;
        longint                held;
        logic [TIME_WIDTH-1:0] chk_time;
        logic [TIME_WIDTH-1:0] alert_time;
        bit                    chk_valid;
        bit                    alert_valid;
        glide_result_t         expected_results[$];
        int                    errors;

        function new();
            check_interval = RST_CHECK_INTERVAL;
            gap_before     = RST_GAP_BEFORE;
            gap_final      = RST_GAP_FINAL;
            upper          = RST_UPPER_MARGIN;
            lower          = RST_LOWER_MARGIN;
            reach          = RST_REACH_MARGIN;
            filt           = 0;
            held           = 0;
            chk_time       = '0;
            alert_time     = '0;
            chk_valid      = 0;
            alert_valid    = 0;
            errors         = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
                                logic [CFG_DATA_WIDTH-1:0] data);
            case (idx)
                REG_CHECK_INTERVAL: check_interval = data;
                REG_GAP_BEFORE:     gap_before = data;
                REG_GAP_FINAL:      gap_final = data;
                REG_UPPER_MARGIN:   upper = longint'($signed(data[MW-1:0]));
                REG_LOWER_MARGIN:   lower = longint'($signed(data[MW-1:0]));
                REG_REACH_MARGIN:   reach = longint'(data[MW-2:0]);
                default: ;
            endcase
        endfunction

        function longint glide_filter(longint m, longint f);
            longint acc;
            acc = (m * NEW_WEIGHT + f * OLD_WEIGHT + HALF_LSB) >>> 16;
            if (acc > MARGIN_MAX)
                acc = MARGIN_MAX;
            if (acc < MARGIN_MIN)
                acc = MARGIN_MIN;
            return acc;
        endfunction

        function void take_update(glide_update_t u);
            bit                    restart;
            bit                    due;
            bit                    raise;
            bit                    free;
            logic [TIME_WIDTH-1:0] gap;
            logic [ALERT_WIDTH-1:0] code;
            glide_result_t         r;
            restart = 0;
            due     = 0;
            raise   = 0;
            code    = ALERT_NONE;
            if (u.flying && u.time_ms != '0)
            begin
                if (!chk_valid || u.time_ms < chk_time)
                begin
                    alert_valid = 0;
                    restart     = 1;
                    due         = 1;
                end
                else if ({1'b0, u.time_ms} >= {1'b0, chk_time} + {1'b0, check_interval})
                begin
                    due = 1;
                end
                if (due)
                begin
                    gap       = gap_before;
                    chk_time  = u.time_ms;
                    chk_valid = 1;
                    if (u.has_task)
                    begin
                        filt = glide_filter(longint'(u.margin), filt);
                        if (!u.on_final)
                        begin
                            if (filt > upper && held < lower)
                                raise = 1;
                            else if (filt < lower)
                                held = filt;
                        end
                        else
                        begin
                            gap = gap_final;
                            if (held < lower && filt > reach)
                            begin
                                raise = 1;
                            end
                            else if (held > reach && filt < lower)
                            begin
                                held  = filt;
                                raise = 1;
                            end
                        end
                    end
                    if (raise && !restart)
                    begin
                        free = !alert_valid || u.time_ms < alert_time ||
                               {1'b0, u.time_ms} >= {1'b0, alert_time} + {1'b0, gap};
                        if (free)
                        begin
                            alert_time  = u.time_ms;
                            alert_valid = 1;
                            if (filt > reach)
                                code = ALERT_ABOVE;
                            else if (filt < -reach)
                                code = ALERT_BELOW;
                            held = filt;
                        end
                    end
                    if (restart)
                        held = filt;
                end
            end
            r.alert  = code;
            r.margin = filt[MW-1:0];
            expected_results.push_back(r);
        endfunction

        task match_result(logic [ALERT_WIDTH-1:0] alert, logic [MW-1:0] margin);
            glide_result_t e;
            if (expected_results.size() == 0)
            begin
                report("result transaction with nothing expected");
            end
            else
            begin
                e = expected_results.pop_front();
                if (alert !== e.alert)
                    report($sformatf("alert %0d, expected %0d", alert, e.alert));
                if (margin !== e.margin)
                    report($sformatf("filtered margin %0d, expected %0d",
                                     $signed(margin), $signed(e.margin)));
            end
        endtask
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    fgta_in_if  #(.MARGIN_WIDTH(MW)) upd_if ();
    fgta_out_if #(.MARGIN_WIDTH(MW)) res_if ();

    final_glide_transition_alert_unit #(.MARGIN_WIDTH(MW)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (upd_if.sink),
        .out_ch    (res_if.source)
    );

    alert_tracker  tracker;
    glide_update_t seen_update;
    int            burst_left;
    bit            steady;
    bit            hold_off;
    int            stall_mode;
    int            stall_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (upd_if.valid && upd_if.ready)
            begin
                seen_update.time_ms    = upd_if.time_ms;
                seen_update.flying     = upd_if.flying;
                seen_update.has_task   = upd_if.has_task;
                seen_update.on_final   = upd_if.on_final_glide;
                seen_update.margin     = upd_if.altitude_margin;
                tracker.take_update(seen_update);
            end
            if (res_if.valid && res_if.ready)
                tracker.match_result(res_if.alert, res_if.filtered_margin);
        end
    end

    // result side stalls
    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 0;
            end
            else
            begin
                case (stall_mode)
                    1: res_if.ready <= ($urandom_range(0, 9) > 2);
                    2:
                    begin
                        stall_count++;
                        res_if.ready <= ((stall_count % 5) > 1);
                    end
                    default: res_if.ready <= 1'b1;
                endcase
            end
        end
    end

    task automatic send_update(input logic [TIME_WIDTH-1:0] t, input bit fly,
                               input bit tv, input bit fin,
                               input logic signed [MW-1:0] m);
        if (burst_left == 0)
        begin
            if (!steady)
            begin
                upd_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        upd_if.valid           <= 1'b1;
        upd_if.time_ms         <= t;
        upd_if.flying          <= fly;
        upd_if.has_task        <= tv;
        upd_if.on_final_glide  <= fin;
        upd_if.altitude_margin <= m;
        @(posedge clk);
        while (!upd_if.ready) @(posedge clk);
    endtask

    task automatic settle();
        upd_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.write_reg(idx, data);
    endtask

    task automatic load_settings(input logic [31:0] chk, input logic [31:0] early_gap,
                                 input logic [31:0] fin_gap, input logic [31:0] up,
                                 input logic [31:0] low, input logic [31:0] reach);
        put_reg(REG_CHECK_INTERVAL, chk);
        put_reg(REG_GAP_BEFORE, early_gap);
        put_reg(REG_GAP_FINAL, fin_gap);
        put_reg(REG_UPPER_MARGIN, up);
        put_reg(REG_LOWER_MARGIN, low);
        put_reg(REG_REACH_MARGIN, reach);
        put_reg(($urandom_range(0, 1) != 0) ? REG_UNUSED_A : REG_UNUSED_B, $urandom);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int n, input logic [31:0] start,
                             input bit pause_mid, input bit hold_mid);
        logic [TIME_WIDTH-1:0] now;
        logic [TIME_WIDTH-1:0] scale;
        logic [TIME_WIDTH-1:0] t;
        longint                target;
        bit                    fin;
        bit                    fly;
        bit                    tv;
        bit                    fn;
        int                    swing;
        int                    kind;
        logic signed [MW-1:0]  m;
        now    = start;
        fin    = 0;
        swing  = 0;
        target = -20000;
        scale  = (tracker.check_interval > 3000) ? 32'd1500 : tracker.check_interval + 1;
        steady = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < n; i++)
        begin
            if (hold_mid && i == n / 2)
                hold_off = 1;
            if (pause_mid && i == (3 * n) / 4)
                settle();
            if (swing == 0)
            begin
                swing  = $urandom_range(4, 20);
                target = (target < 0) ? longint'($urandom_range(12000, 60000))
                                      : -longint'($urandom_range(12000, 60000));
                if ($urandom_range(0, 3) == 0)
                    fin = !fin;
            end
            swing--;
            kind = $urandom_range(0, 99);
            fly  = 1;
            tv   = 1;
            fn   = fin;
            m    = MW'(target + longint'($urandom_range(0, 4000)) - 2000);
            if (kind < 4)
            begin
                // not flying
                t   = $urandom;
                fly = 0;
                tv  = 1'($urandom_range(0, 1));
                fn  = 1'($urandom_range(0, 1));
                m   = MW'($urandom);
            end
            else if (kind < 6)
            begin
                t  = '0;
                tv = 1'($urandom_range(0, 1));
                fn = 1'($urandom_range(0, 1));
            end
            else if (kind < 9)
            begin
                // time steps backwards
                now = now - $urandom_range(1, 3000);
                t   = now;
            end
            else if (kind < 13)
            begin
                t   = $urandom;
                now = t;
                fly = 1'($urandom_range(0, 1));
                tv  = 1'($urandom_range(0, 1));
                fn  = 1'($urandom_range(0, 1));
                m   = MW'($urandom);
            end
            else
            begin
                now = now + $urandom_range(0, 2 * scale);
                t   = now;
                tv  = ($urandom_range(0, 15) != 0);
            end
            send_update(t, fly, tv, fn, m);
        end
    endtask

    initial
    begin
        tracker     = new();
        burst_left  = 0;
        steady      = 0;
        hold_off    = 0;
        stall_mode  = 1;
        stall_count = 0;
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= REG_CHECK_INTERVAL;
        cfg_data               <= '0;
        upd_if.valid           <= 1'b0;
        upd_if.time_ms         <= '0;
        upd_if.flying          <= 1'b0;
        upd_if.has_task        <= 1'b0;
        upd_if.on_final_glide  <= 1'b0;
        upd_if.altitude_margin <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: ignored items, first check, holds, events and gaps
        send_update(32'd5000, 0, 1, 0, MARGIN_TOP);
        send_update(32'd0, 1, 1, 0, MARGIN_TOP);
        send_update(32'd1000, 1, 1, 0, MARGIN_BOTTOM);
        send_update(32'd1500, 1, 1, 0, MARGIN_BOTTOM);
        send_update(32'd2000, 1, 0, 0, MARGIN_TOP);
        for (int k = 3; k < 7; k++)
            send_update(k * 1000, 1, 1, 0, MARGIN_TOP);
        for (int k = 8; k < 11; k++)
            send_update(k * 1000, 1, 1, 1, MARGIN_BOTTOM);
        send_update(32'd70000, 1, 1, 1, MARGIN_TOP);
        send_update(32'd71000, 1, 1, 1, MARGIN_BOTTOM);
        send_update(32'd72000, 1, 1, 1, MARGIN_BOTTOM);
        send_update(32'd140000, 1, 1, 1, MARGIN_TOP);
        send_update(32'd201000, 1, 1, 1, MARGIN_BOTTOM);
        send_update(32'd262000, 1, 1, 1, MARGIN_BOTTOM);
        send_update(32'd323000, 1, 1, 1, MARGIN_BOTTOM);
        send_update(32'd50000, 1, 1, 0, '0);
        send_update(32'hFFFF_FE00, 1, 1, 0, '0);
        send_update(32'hFFFF_FFFF, 1, 1, 0, MARGIN_TOP);
        send_update(32'h0000_0001, 1, 1, 0, 24'sh5A5A5A);
        settle();

        stall_mode = 0;
        run_phase(170, 32'd200000, 1, 1);
        settle();

        load_settings(200, 2000, 1000, 3000, -3000, 256);
        stall_mode = 1;
        run_phase(200, $urandom, 0, 0);
        settle();

        load_settings(0, 0, 0, 0, 0, 0);
        stall_mode = 2;
        run_phase(170, $urandom, 1, 0);
        settle();

        load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFF7F_FFFF, 32'h0080_0000, 32'hFFFF_FFFF);
        stall_mode = 0;
        run_phase(200, $urandom, 0, 0);
        settle();

        load_settings($urandom_range(0, 1500), $urandom_range(0, 20000),
                      $urandom_range(0, 20000), $urandom_range(0, 20000),
                      -$urandom_range(0, 20000), $urandom_range(0, 6000));
        stall_mode = 1;
        run_phase(200, 32'hFFFF_0000 - $urandom_range(0, 200000), 1, 1);
        settle();

        // thresholds that put events inside the reach band
        load_settings($urandom_range(0, 800), $urandom_range(0, 3000),
                      $urandom_range(0, 3000), $urandom_range(0, 2000),
                      -$urandom_range(2000, 20000), $urandom_range(2000, 8000));
        stall_mode = 2;
        run_phase(200, $urandom, 0, 0);

        upd_if.valid <= 1'b0;
        @(posedge clk);
        for (int w = 0; w < 4000 && tracker.pending() != 0; w++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d results never arrived", tracker.pending()));
        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
